// File: hw/rtl/kcl_pkg.sv
// Shared types and constants of the keypad code lock.
`default_nettype none

package kcl_pkg;

	// Default sizes
	localparam int USERS_DEF      = 5;
	localparam int MAX_DIGITS_DEF = 8;

	// Code lengths a user entry can hold
	localparam int SHORT_LEN = 4;
	localparam int LONG_LEN  = 8;

	// Item modes
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_PRESS = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	localparam logic [2:0] BTN_CENTER = 3'd4;

	// Lock phases
	localparam logic [1:0] PH_STANDBY = 2'd0;
	localparam logic [1:0] PH_SLEEP   = 2'd1;
	localparam logic [1:0] PH_ENTRY   = 2'd2;
	localparam logic [1:0] PH_LOCKOUT = 2'd3;

	// Result events
	localparam logic [3:0] EV_NONE        = 4'd0;
	localparam logic [3:0] EV_WOKE        = 4'd1;
	localparam logic [3:0] EV_DIGIT       = 4'd2;
	localparam logic [3:0] EV_ENTRY_TMO   = 4'd3;
	localparam logic [3:0] EV_GRANTED     = 4'd4;
	localparam logic [3:0] EV_DENIED      = 4'd5;
	localparam logic [3:0] EV_LOCK_START  = 4'd6;
	localparam logic [3:0] EV_LOCK_END    = 4'd7;
	localparam logic [3:0] EV_TO_STANDBY  = 4'd8;
	localparam logic [3:0] EV_TO_SLEEP    = 4'd9;
	localparam logic [3:0] EV_TABLE_WR    = 4'd10;

	// Configuration register indexes
	localparam logic [1:0] CFG_INACTIVITY = 2'd0;
	localparam logic [1:0] CFG_ENTRY      = 2'd1;
	localparam logic [1:0] CFG_LOCKOUT    = 2'd2;
	localparam logic [1:0] CFG_MAX_FAIL   = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic [15:0] INACTIVITY_RST = 16'd30000;
	localparam logic [15:0] ENTRY_RST      = 16'd15000;
	localparam logic [15:0] LOCKOUT_RST    = 16'd30000;
	localparam logic [3:0]  MAX_FAIL_RST   = 4'd3;

	localparam logic [15:0] TICK_SAT = 16'hFFFF;
	localparam logic [3:0]  FAIL_SAT = 4'd15;

	// One user table entry
	typedef struct packed {
		logic        active;
		logic        is_long;
		logic [15:0] code;
	} user_entry_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  button;
		logic [2:0]  user_slot;
		logic        slot_active;
		logic        slot_long;
		logic [15:0] slot_code;
	} in_item_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [3:0] event_res;
		logic [2:0] user_index;
		logic [3:0] digits_entered;
		logic [3:0] failures;
	} out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/kcl_if.sv
// Input and result channel interfaces of the keypad code lock.
`default_nettype none

interface kcl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [2:0]  button;
	logic [2:0]  user_slot;
	logic        slot_active;
	logic        slot_long;
	logic [15:0] slot_code;

	modport source (output valid, mode, button, user_slot, slot_active, slot_long,
		slot_code, input ready);
	modport sink (input valid, mode, button, user_slot, slot_active, slot_long,
		slot_code, output ready);
endinterface

interface kcl_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] phase;
	logic [3:0] event_res;
	logic [2:0] user_index;
	logic [3:0] digits_entered;
	logic [3:0] failures;

	modport source (output valid, phase, event_res, user_index, digits_entered, failures,
		input ready);
	modport sink (input valid, phase, event_res, user_index, digits_entered, failures,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/multi_user_keypad_code_lock_top.sv
// Keypad code lock with a user table: top level.
// Usage:
//   in_ch carries one item: a 1 ms tick, a button press or a user table write.
//   out_ch returns exactly one result item per input item, in order: the phase
//   after the item, an event code, the granted user, digit count and failures.
//   cfg_we/cfg_index/cfg_data write the four limits; write only while idle.
// Timing:
//   One item at a time. A tick, a digit or a table write passes the execute
//   step and then the output register. A submit in entry scans the user table
//   in its memory, one entry per cycle behind the registered read port, and
//   stops at the first match or after the last entry when nothing matches.
//   in_ch.ready is high whenever no item is in flight, so the next item can be
//   taken while a finished result still sits in the output register.
// Reset: arst_n clears all control state, sets limits to reset values; table
//   entries read inactive through per-entry valid flags, with no clearing pass.
// Stall: while out_ch.ready is low the next result waits in a hold register
//   and no further item is accepted until the output register drains.
`default_nettype none

module multi_user_keypad_code_lock_top #(
	parameter int USERS      = kcl_pkg::USERS_DEF,
	parameter int MAX_DIGITS = kcl_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
	kcl_in_if.sink                             in_ch,
	kcl_out_if.source                          out_ch
);

	localparam int AW  = (USERS > 1) ? $clog2(USERS) : 1;   // table address
	localparam int SW  = $clog2(USERS + 1);                 // scan counter
	localparam int EW  = 2 * MAX_DIGITS;                    // entered digits
	localparam int CW  = (EW > 16) ? EW : 16;               // compare view
	localparam int DCW = $clog2(MAX_DIGITS + 1);            // digit count

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] st_q;

	// Configuration
	logic [15:0] inact_lim_q, entry_lim_q, lock_len_q;
	logic [3:0]  max_fail_q;

	// Lock state
	logic [1:0]     phase_q;
	logic [EW-1:0]  digits_q;
	logic [DCW-1:0] count_q;
	logic           run_q;
	logic [15:0]    eticks_q, idle_q, lticks_q;
	logic [3:0]     fail_q;

	// Item and result holding
	kcl_pkg::in_item_t  item_q;
	kcl_pkg::out_item_t res_q, out_q;
	logic               out_vld_q;

	// User table memory, valid flags give the reset view
	kcl_pkg::user_entry_t mem [USERS];
	kcl_pkg::user_entry_t rd_data_s1;
	logic [USERS-1:0]     tbl_vld_q;
	logic                 rd_tbl_vld_s1;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;

	// Table scan
	logic [SW-1:0] scan_idx_q;
	logic          chk_s1;
	logic [AW-1:0] chk_idx_s1;
	logic          match;
	logic          scan_fin;
	logic          hit;

	logic [CW-1:0] digits_ext;
	logic          need_scan;
	logic          commit;

	// Next values
	logic [1:0]     nxt_phase;
	logic [EW-1:0]  nxt_digits;
	logic [DCW-1:0] nxt_count;
	logic           nxt_run;
	logic [15:0]    nxt_eticks, nxt_idle, nxt_lticks;
	logic [3:0]     nxt_fail;
	logic [3:0]     ev;
	logic [2:0]     usr;
	logic [15:0]    idle_inc, eticks_inc, lticks_inc;
	logic [3:0]     fail_inc;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == kcl_pkg::TICK_SAT) ? v : v + 16'd1;
	endfunction

	assign in_ch.ready = (st_q == ST_IDLE);

	assign out_ch.valid          = out_vld_q;
	assign out_ch.phase          = out_q.phase;
	assign out_ch.event_res      = out_q.event_res;
	assign out_ch.user_index     = out_q.user_index;
	assign out_ch.digits_entered = out_q.digits_entered;
	assign out_ch.failures       = out_q.failures;

	// Submit while in entry is the only item that walks the table
	assign need_scan = (item_q.mode == kcl_pkg::MODE_PRESS) &&
		(item_q.button == kcl_pkg::BTN_CENTER) && (phase_q == kcl_pkg::PH_ENTRY);

	assign wr_en = (st_q == ST_EXEC) && (item_q.mode == kcl_pkg::MODE_WRITE) &&
		(32'(item_q.user_slot) < USERS);

	// Scan: issue one read a cycle, check the entry read in the cycle before.
	// Table writes only come from earlier items, so no read can overlap a write.
	assign rd_en   = (st_q == ST_SCAN) && (scan_idx_q < SW'(USERS));
	assign rd_addr = scan_idx_q[AW-1:0];

	assign digits_ext = CW'(digits_q);

	always_comb begin
		match = 1'b0;
		if (rd_tbl_vld_s1 && rd_data_s1.active) begin
			if (rd_data_s1.is_long)
				match = (32'(count_q) == kcl_pkg::LONG_LEN) &&
					(digits_ext[15:0] == rd_data_s1.code);
			else
				match = (32'(count_q) == kcl_pkg::SHORT_LEN) &&
					(digits_ext[7:0] == rd_data_s1.code[7:0]);
		end
	end

	assign hit      = chk_s1 && match;
	assign scan_fin = chk_s1 && (match || (32'(chk_idx_s1) == USERS - 1));
	assign commit   = ((st_q == ST_EXEC) && !need_scan) || ((st_q == ST_SCAN) && scan_fin);

	// Item behavior
	always_comb begin
		nxt_phase  = phase_q;
		nxt_digits = digits_q;
		nxt_count  = count_q;
		nxt_run    = run_q;
		nxt_eticks = eticks_q;
		nxt_idle   = idle_q;
		nxt_fail   = fail_q;
		nxt_lticks = lticks_q;
		ev         = kcl_pkg::EV_NONE;
		usr        = 3'd0;
		idle_inc   = sat_inc(idle_q);
		eticks_inc = sat_inc(eticks_q);
		lticks_inc = sat_inc(lticks_q);
		fail_inc   = (fail_q < kcl_pkg::FAIL_SAT) ? fail_q + 4'd1 : fail_q;

		case (item_q.mode)
			kcl_pkg::MODE_TICK: begin
				case (phase_q)
					kcl_pkg::PH_STANDBY: begin
						nxt_idle = idle_inc;
						if (idle_inc >= inact_lim_q) begin
							nxt_phase = kcl_pkg::PH_SLEEP;
							nxt_idle  = '0;
							ev        = kcl_pkg::EV_TO_SLEEP;
						end
					end
					kcl_pkg::PH_ENTRY: begin
						nxt_idle = idle_inc;
						if (idle_inc >= inact_lim_q) begin
							nxt_phase  = kcl_pkg::PH_STANDBY;
							nxt_digits = '0;
							nxt_count  = '0;
							nxt_run    = 1'b0;
							nxt_eticks = '0;
							nxt_idle   = '0;
							ev         = kcl_pkg::EV_TO_STANDBY;
						end else if (run_q) begin
							nxt_eticks = eticks_inc;
							if (eticks_inc >= entry_lim_q) begin
								nxt_digits = '0;
								nxt_count  = '0;
								nxt_run    = 1'b0;
								nxt_eticks = '0;
								nxt_idle   = '0;
								ev         = kcl_pkg::EV_ENTRY_TMO;
							end
						end
					end
					kcl_pkg::PH_LOCKOUT: begin
						nxt_lticks = lticks_inc;
						if (lticks_inc >= lock_len_q) begin
							nxt_phase  = kcl_pkg::PH_ENTRY;
							nxt_lticks = '0;
							nxt_fail   = '0;
							nxt_idle   = '0;
							nxt_digits = '0;
							nxt_count  = '0;
							nxt_run    = 1'b0;
							nxt_eticks = '0;
							ev         = kcl_pkg::EV_LOCK_END;
						end
					end
					default: ;  // sleep ignores ticks
				endcase
			end
			kcl_pkg::MODE_PRESS: begin
				if (item_q.button > kcl_pkg::BTN_CENTER) begin
					ev = kcl_pkg::EV_NONE;
				end else if (phase_q inside {kcl_pkg::PH_STANDBY, kcl_pkg::PH_SLEEP}) begin
					if (item_q.button == kcl_pkg::BTN_CENTER) begin
						nxt_phase  = kcl_pkg::PH_ENTRY;
						nxt_digits = '0;
						nxt_count  = '0;
						nxt_run    = 1'b0;
						nxt_eticks = '0;
						nxt_idle   = '0;
						ev         = kcl_pkg::EV_WOKE;
					end
				end else if (phase_q == kcl_pkg::PH_ENTRY) begin
					nxt_idle = '0;
					if (count_q == '0 && !run_q) begin
						nxt_run    = 1'b1;
						nxt_eticks = '0;
					end
					if (item_q.button == kcl_pkg::BTN_CENTER) begin
						nxt_digits = '0;
						nxt_count  = '0;
						nxt_run    = 1'b0;
						nxt_eticks = '0;
						if (hit) begin
							usr       = 3'(chk_idx_s1);
							nxt_fail  = '0;
							nxt_phase = kcl_pkg::PH_STANDBY;
							ev        = kcl_pkg::EV_GRANTED;
						end else begin
							nxt_fail = fail_inc;
							if (fail_inc >= max_fail_q) begin
								nxt_phase  = kcl_pkg::PH_LOCKOUT;
								nxt_lticks = '0;
								ev         = kcl_pkg::EV_LOCK_START;
							end else begin
								ev = kcl_pkg::EV_DENIED;
							end
						end
					end else if (32'(count_q) < MAX_DIGITS) begin
						nxt_digits = digits_q |
							(EW'(item_q.button[1:0]) << {count_q, 1'b0});
						nxt_count  = count_q + DCW'(1);
						ev         = kcl_pkg::EV_DIGIT;
					end
				end
			end
			kcl_pkg::MODE_WRITE: begin
				if (32'(item_q.user_slot) < USERS)
					ev = kcl_pkg::EV_TABLE_WR;
			end
			default: ;  // unused mode
		endcase
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[item_q.user_slot[AW-1:0]] <= '{active: item_q.slot_active,
				is_long: item_q.slot_long, code: item_q.slot_code};
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			item_q <= '{mode: in_ch.mode, button: in_ch.button,
				user_slot: in_ch.user_slot, slot_active: in_ch.slot_active,
				slot_long: in_ch.slot_long, slot_code: in_ch.slot_code};
		if (commit)
			res_q <= '{phase: nxt_phase, event_res: ev, user_index: usr,
				digits_entered: 4'(nxt_count), failures: nxt_fail};
		if (st_q == ST_DONE && (!out_vld_q || out_ch.ready))
			out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			inact_lim_q   <= kcl_pkg::INACTIVITY_RST;
			entry_lim_q   <= kcl_pkg::ENTRY_RST;
			lock_len_q    <= kcl_pkg::LOCKOUT_RST;
			max_fail_q    <= kcl_pkg::MAX_FAIL_RST;
			phase_q       <= kcl_pkg::PH_STANDBY;
			digits_q      <= '0;
			count_q       <= '0;
			run_q         <= 1'b0;
			eticks_q      <= '0;
			idle_q        <= '0;
			fail_q        <= '0;
			lticks_q      <= '0;
			out_vld_q     <= 1'b0;
			tbl_vld_q     <= '0;
			rd_tbl_vld_s1 <= 1'b0;
			scan_idx_q    <= '0;
			chk_s1        <= 1'b0;
			chk_idx_s1    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kcl_pkg::CFG_INACTIVITY: inact_lim_q <= cfg_data;
					kcl_pkg::CFG_ENTRY:      entry_lim_q <= cfg_data;
					kcl_pkg::CFG_LOCKOUT:    lock_len_q  <= cfg_data;
					kcl_pkg::CFG_MAX_FAIL:   max_fail_q  <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (wr_en)
				tbl_vld_q[item_q.user_slot[AW-1:0]] <= 1'b1;

			// Scan pipeline; rd_en is low outside the scan, so this also clears the check
			chk_s1 <= rd_en;
			if (rd_en) begin
				chk_idx_s1    <= rd_addr;
				rd_tbl_vld_s1 <= tbl_vld_q[rd_addr];
				scan_idx_q    <= scan_idx_q + SW'(1);
			end

			if (commit) begin
				phase_q  <= nxt_phase;
				digits_q <= nxt_digits;
				count_q  <= nxt_count;
				run_q    <= nxt_run;
				eticks_q <= nxt_eticks;
				idle_q   <= nxt_idle;
				fail_q   <= nxt_fail;
				lticks_q <= nxt_lticks;
			end

			// Output register: load a finished result, else drain on handshake
			if (st_q == ST_DONE && (!out_vld_q || out_ch.ready))
				out_vld_q <= 1'b1;
			else if (out_vld_q && out_ch.ready)
				out_vld_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (in_ch.valid)
						st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (need_scan) begin
						st_q       <= ST_SCAN;
						scan_idx_q <= '0;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (scan_fin)
						st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_vld_q || out_ch.ready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
